>>> hw/rtl/stg_pkg.sv
package stg_pkg;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_PHASE_INC = 2'd0,
        CFG_AMPLITUDE = 2'd1,
        CFG_CHANNELS  = 2'd2
    } t_cfg_reg;

    localparam int CfgAddrBits   = 2;
    localparam int CfgDataBits   = 32;
    localparam int IncBits       = 32;
    localparam int AmpBits       = 15;
    localparam int ChanCfgBits   = 4;
    localparam int ChIdxBits     = 3;
    localparam int SampleBits    = 16;
    localparam int TblValBits    = 16;
    localparam int MaxChannels   = 8;

    localparam logic [IncBits-1:0]     IncReset  = 32'd39370534;
    localparam logic [AmpBits-1:0]     AmpReset  = 15'd8000;
    localparam logic [ChanCfgBits-1:0] ChanReset = 4'd2;

    // pi/2 in Q30
    localparam logic [63:0] HalfPiQ30 = 64'd1686629713;

    // quarter-wave sine entry in unsigned Q15, taylor series in Q30, elaboration only
    function automatic logic [TblValBits-1:0] sine_q15(input int unsigned k,
                                                       input int unsigned addr_bits);
        logic [63:0] theta;
        logic [63:0] theta2;
        logic [63:0] term;
        logic [63:0] pos;
        logic [63:0] neg;
        logic [63:0] sum;
        theta  = (HalfPiQ30 * 64'(k)) >> addr_bits;
        theta2 = (theta * theta) >> 30;
        term   = theta;
        pos    = theta;
        neg    = 64'd0;
        term   = ((term * theta2) >> 30) / 64'd6;
        neg    = neg + term;
        term   = ((term * theta2) >> 30) / 64'd20;
        pos    = pos + term;
        term   = ((term * theta2) >> 30) / 64'd42;
        neg    = neg + term;
        term   = ((term * theta2) >> 30) / 64'd72;
        pos    = pos + term;
        term   = ((term * theta2) >> 30) / 64'd110;
        neg    = neg + term;
        term   = ((term * theta2) >> 30) / 64'd156;
        pos    = pos + term;
        term   = ((term * theta2) >> 30) / 64'd210;
        neg    = neg + term;
        sum    = (pos > neg) ? (pos - neg) : 64'd0;
        sum    = (sum + 64'd16384) >> 15;
        if (sum > 64'd32768) begin
            sum = 64'd32768;
        end
        return sum[TblValBits-1:0];
    endfunction

endpackage

>>> hw/rtl/stg_front.sv
module stg_front
    import stg_pkg::*;
#(
    parameter int PHASE_BITS      = 32,
    parameter int TABLE_ADDR_BITS = 10,
    parameter int ENTRY_BITS      = TABLE_ADDR_BITS + 6
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic                   i_restart,
    input  logic                   i_bend,
    input  logic [IncBits-1:0]     i_phase_inc,
    input  logic [ChanCfgBits-1:0] i_channels,
    input  logic                   i_full,
    output logic                   o_push,
    output logic [ENTRY_BITS-1:0]  o_entry
);

    localparam int IdxLsb = PHASE_BITS - 2 - TABLE_ADDR_BITS;

    logic [PHASE_BITS-1:0]      r_phase;
    logic [PHASE_BITS-1:0]      n_phase;
    logic [PHASE_BITS-1:0]      w_base;
    logic [1:0]                 w_quad;
    logic [TABLE_ADDR_BITS-1:0] w_idx;
    logic [TABLE_ADDR_BITS:0]   w_addr;
    logic [ChIdxBits-1:0]       w_last_ch;

    // request accepted whenever the queue has room
    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;

    // phase step, restart drops the old phase before the add
    assign w_base  = i_restart ? '0 : r_phase;
    assign n_phase = w_base + PHASE_BITS'(i_phase_inc);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
        end else if (o_push) begin
            r_phase <= n_phase;
        end
    end

    // quadrant and mirrored table address
    assign w_quad = n_phase[PHASE_BITS-1 -: 2];
    assign w_idx  = n_phase[IdxLsb +: TABLE_ADDR_BITS];
    assign w_addr = w_quad[0] ? ((TABLE_ADDR_BITS+1)'(1) << TABLE_ADDR_BITS) - {1'b0, w_idx}
                              : {1'b0, w_idx};

    // channel count clamped to 1..8, kept as last channel index
    always_comb begin
        if (i_channels == '0) begin
            w_last_ch = '0;
        end else if (i_channels > ChanCfgBits'(MaxChannels)) begin
            w_last_ch = ChIdxBits'(MaxChannels - 1);
        end else begin
            w_last_ch = ChIdxBits'(i_channels - 1'b1);
        end
    end

    assign o_entry = {w_quad[1], w_addr, i_bend, w_last_ch};

endmodule

>>> hw/rtl/stg_queue.sv
module stg_queue #(
    parameter int WIDTH = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wr;
    logic             r_rd;
    logic [1:0]       r_cnt;
    logic             w_do_pop;

    assign o_full   = (r_cnt == 2'd2);
    assign o_valid  = (r_cnt != 2'd0);
    assign o_data   = r_mem[r_rd];
    assign w_do_pop = i_pop && o_valid;

    // two-entry ring
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= !r_wr;
            end
            if (w_do_pop) begin
                r_rd <= !r_rd;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, w_do_pop};
        end
    end

endmodule

>>> hw/rtl/stg_back.sv
module stg_back
    import stg_pkg::*;
#(
    parameter int TABLE_ADDR_BITS = 10,
    parameter int ENTRY_BITS      = TABLE_ADDR_BITS + 6
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_q_valid,
    input  logic [ENTRY_BITS-1:0]  i_q_data,
    output logic                   o_q_pop,
    input  logic [AmpBits-1:0]     i_amplitude,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [SampleBits-1:0]  o_sample,
    output logic [ChIdxBits-1:0]   o_channel,
    output logic                   o_frame_last,
    output logic                   o_buffer_last
);

    localparam int TblDepth = (1 << TABLE_ADDR_BITS) + 1;
    localparam int ProdBits = TblValBits + AmpBits;

    // constant quarter-wave table
    logic [TblValBits-1:0] w_rom [TblDepth];

    for (genvar k = 0; k < TblDepth; k++) begin : g_rom
        assign w_rom[k] = sine_q15(k, TABLE_ADDR_BITS);
    end

    // queue entry fields
    logic                     w_q_sign;
    logic [TABLE_ADDR_BITS:0] w_q_addr;
    logic                     w_q_bend;
    logic [ChIdxBits-1:0]     w_q_last;

    assign {w_q_sign, w_q_addr, w_q_bend, w_q_last} = i_q_data;

    // stage a: table read
    logic                  r_a_valid;
    logic [TblValBits-1:0] r_a_tbl;
    logic                  r_a_sign;
    logic                  r_a_bend;
    logic [ChIdxBits-1:0]  r_a_last;

    // stage b: scaled sample
    logic                  r_b_valid;
    logic [SampleBits-1:0] r_b_sample;
    logic                  r_b_bend;
    logic [ChIdxBits-1:0]  r_b_last;

    // emitter: one channel copy per cycle while i_ready is high
    logic                  r_e_valid;
    logic [SampleBits-1:0] r_e_sample;
    logic                  r_e_bend;
    logic [ChIdxBits-1:0]  r_e_last;
    logic [ChIdxBits-1:0]  r_e_ch;

    logic                  w_out_acc;
    logic                  w_e_done;
    logic                  w_e_load;
    logic                  w_b_load;
    logic                  w_a_load;
    logic [ProdBits-1:0]   w_prod;
    logic [AmpBits-1:0]    w_mag;
    logic [SampleBits-1:0] w_sample;

    // stage advance, each stage loads when empty or draining
    assign w_out_acc = r_e_valid && i_ready;
    assign w_e_done  = w_out_acc && (r_e_ch == r_e_last);
    assign w_e_load  = r_b_valid && (!r_e_valid || w_e_done);
    assign w_b_load  = r_a_valid && (!r_b_valid || w_e_load);
    assign w_a_load  = i_q_valid && (!r_a_valid || w_b_load);
    assign o_q_pop   = w_a_load;

    // scale by amplitude, truncate, then apply quadrant sign
    assign w_prod   = ProdBits'(r_a_tbl) * ProdBits'(i_amplitude);
    assign w_mag    = w_prod[AmpBits +: AmpBits];
    assign w_sample = r_a_sign ? -{1'b0, w_mag} : {1'b0, w_mag};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_e_valid <= 1'b0;
            r_e_ch    <= '0;
        end else begin
            if (w_a_load) begin
                r_a_valid <= 1'b1;
            end else if (w_b_load) begin
                r_a_valid <= 1'b0;
            end
            if (w_b_load) begin
                r_b_valid <= 1'b1;
            end else if (w_e_load) begin
                r_b_valid <= 1'b0;
            end
            if (w_e_load) begin
                r_e_valid <= 1'b1;
                r_e_ch    <= '0;
            end else if (w_e_done) begin
                r_e_valid <= 1'b0;
            end else if (w_out_acc) begin
                r_e_ch    <= r_e_ch + 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_a_load) begin
            r_a_tbl  <= w_rom[w_q_addr];
            r_a_sign <= w_q_sign;
            r_a_bend <= w_q_bend;
            r_a_last <= w_q_last;
        end
        if (w_b_load) begin
            r_b_sample <= w_sample;
            r_b_bend   <= r_a_bend;
            r_b_last   <= r_a_last;
        end
        if (w_e_load) begin
            r_e_sample <= r_b_sample;
            r_e_bend   <= r_b_bend;
            r_e_last   <= r_b_last;
        end
    end

    assign o_valid       = r_e_valid;
    assign o_sample      = r_e_sample;
    assign o_channel     = r_e_ch;
    assign o_frame_last  = (r_e_ch == r_e_last);
    assign o_buffer_last = o_frame_last && r_e_bend;

endmodule

>>> hw/rtl/sine_tone_generator.sv
// sine tone generator: phase accumulator, quarter-wave table, amplitude scale
// path: frame requests pass the queue, stage a, stage b and the emitter, in that order
// output: each frame gives max(channel_count, 1) copies, clamped to 8; the
//   channel emitter hands out one copy per cycle while m_axis_tready is high
// reset (synchronous, active low): phase zero, registers to defaults, pipeline empty
module sine_tone_generator
    import stg_pkg::*;
#(
    parameter int PHASE_BITS      = 32,
    parameter int TABLE_ADDR_BITS = 10
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // frame requests
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [7:0]             s_axis_tdata,   // [0] restart_phase
    input  logic                   s_axis_tlast,   // buffer_end
    // channel copies
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [SampleBits-1:0]  m_axis_tdata,   // [15:0] sample
    output logic                   m_axis_tlast,   // frame_last
    output logic [3:0]             m_axis_tuser,   // [2:0] channel_index, [3] buffer_last
    // configuration writes
    input  logic                   i_cfg_wr_en,
    input  logic [CfgAddrBits-1:0] i_cfg_addr,
    input  logic [CfgDataBits-1:0] i_cfg_wr_data
);

    localparam int EntryBits = TABLE_ADDR_BITS + 6;

    logic [IncBits-1:0]     r_phase_inc;
    logic [AmpBits-1:0]     r_amplitude;
    logic [ChanCfgBits-1:0] r_channels;

    logic                   w_q_full;
    logic                   w_push;
    logic [EntryBits-1:0]   w_push_data;
    logic                   w_pop;
    logic                   w_q_valid;
    logic [EntryBits-1:0]   w_q_data;
    logic [ChIdxBits-1:0]   w_channel;
    logic                   w_buffer_last;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_inc <= IncReset;
            r_amplitude <= AmpReset;
            r_channels  <= ChanReset;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_addr)
                CFG_PHASE_INC: r_phase_inc <= i_cfg_wr_data[IncBits-1:0];
                CFG_AMPLITUDE: r_amplitude <= i_cfg_wr_data[AmpBits-1:0];
                CFG_CHANNELS:  r_channels  <= i_cfg_wr_data[ChanCfgBits-1:0];
                default: begin
                end
            endcase
        end
    end

    stg_front #(
        .PHASE_BITS      (PHASE_BITS),
        .TABLE_ADDR_BITS (TABLE_ADDR_BITS),
        .ENTRY_BITS      (EntryBits)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_restart   (s_axis_tdata[0]),
        .i_bend      (s_axis_tlast),
        .i_phase_inc (r_phase_inc),
        .i_channels  (r_channels),
        .i_full      (w_q_full),
        .o_push      (w_push),
        .o_entry     (w_push_data)
    );

    stg_queue #(
        .WIDTH (EntryBits)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_data),
        .o_full  (w_q_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_data  (w_q_data)
    );

    stg_back #(
        .TABLE_ADDR_BITS (TABLE_ADDR_BITS),
        .ENTRY_BITS      (EntryBits)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (w_q_valid),
        .i_q_data      (w_q_data),
        .o_q_pop       (w_pop),
        .i_amplitude   (r_amplitude),
        .o_valid       (m_axis_tvalid),
        .i_ready       (m_axis_tready),
        .o_sample      (m_axis_tdata),
        .o_channel     (w_channel),
        .o_frame_last  (m_axis_tlast),
        .o_buffer_last (w_buffer_last)
    );

    assign m_axis_tuser = {w_buffer_last, w_channel};

    // a finished frame is followed by channel zero of the next one
    a_frame_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && m_axis_tlast
        |=> !m_axis_tvalid || (m_axis_tuser[2:0] == '0))
        else $error("next frame does not start at channel zero");

    // copies within a frame step through channels in order
    a_channel_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast
        |=> m_axis_tvalid && (m_axis_tuser[2:0] == $past(m_axis_tuser[2:0]) + 3'd1))
        else $error("channel copy skipped or repeated");

    // buffer end only rides on the last copy of a frame
    a_buffer_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[3] |-> m_axis_tlast)
        else $error("buffer end flagged before frame end");

    // pipeline empty after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid right after reset");

endmodule
